// ===== rtl/bmac_pkg.sv =====
package bmac_pkg;

   // field widths fixed by the request and response formats
   localparam int IDX_W      = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // default geometry of the bitmap store
   localparam int DEF_WORD_BITS  = 64;
   localparam int DEF_WORD_COUNT = 64;

   // configuration register reset values
   localparam logic [IDX_W-1:0] RANGE_LOW_RESET  = 16'd0;
   localparam logic [IDX_W-1:0] RANGE_HIGH_RESET = 16'd4095;

   // register select taken from the word address bit
   localparam logic REG_RANGE_LOW  = 1'b0;
   localparam logic REG_RANGE_HIGH = 1'b1;

   typedef enum logic [1:0] {
      MODE_GET   = 2'd0,
      MODE_SET   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_FIND  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_PARAM = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_MOD,
      ST_READ,
      ST_RMW,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FOUND,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/bmac_req_if.sv =====
interface bmac_req_if import bmac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   mode_type             mode;
   logic [IDX_W-1:0]     block_index;

   modport source (output valid, output mode, output block_index, input ready);
   modport sink (input valid, input mode, input block_index, output ready);
endinterface

// ===== rtl/bmac_rsp_if.sv =====
interface bmac_rsp_if import bmac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic                 bit_value;
   logic [IDX_W-1:0]     free_index;

   modport source (output valid, output status, output bit_value, output free_index,
                   input ready);
   modport sink (input valid, input status, input bit_value, input free_index,
                 output ready);
endinterface

// ===== rtl/bitmap_allocator_with_cursor.sv =====
// channel    | direction | handshake         | payload
// -----------+-----------+-------------------+----------------------------------
// req_bus    | in        | valid / ready     | mode, block_index
// rsp_bus    | out       | valid / ready     | status, bit_value, free_index
// apb csr    | in        | psel / penable    | paddr, pwdata, prdata (pready = 1)
//
// get, set and clear pass prep, multiply, split, read and write before a response is loaded,
// skipping read and write when the index is untracked; find passes prep, multiply, split,
// a scan read, a scan check per word scanned and a found state on a hit, or goes from split
// to the response when the cursor is already past the last word or the range is empty; ready
// returns with the response becoming valid; after reset and each csr write a clearing pass
// zeroes the bitmap; a waiting response stalls the next transaction at its end, not at acceptance
module bitmap_allocator_with_cursor import bmac_pkg::*; #(
   parameter int WORD_BITS  = DEF_WORD_BITS,
   parameter int WORD_COUNT = DEF_WORD_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   bmac_req_if.sink              req_bus,
   bmac_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int BW = $clog2(WORD_BITS);
   localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CW = $clog2(WORD_COUNT + 1);
   localparam logic [IDX_W:0] TOTAL_M1 = (IDX_W+1)'(WORD_BITS * WORD_COUNT - 1);
   // reciprocal for exact division of a 16-bit value by WORD_BITS
   localparam int SH = IDX_W + BW;
   localparam longint RECIP_L = ((64'(1) << SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int RW = IDX_W + 2;
   localparam int PW = IDX_W + RW;
   localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      range_low_ff, range_low_in;
   logic [IDX_W-1:0]      range_high_ff, range_high_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [CW-1:0]         cursor_ff, cursor_in;
   mode_type              mode_ff, mode_in;
   logic [IDX_W-1:0]      index_ff, index_in;
   logic [IDX_W-1:0]      op_ff, op_in;
   logic                  valid_ff, valid_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [CW-1:0]         word_ff, word_in;
   logic [BW-1:0]         bit_ff, bit_in;
   status_type            res_status_ff, res_status_in;
   logic                  res_bit_ff, res_bit_in;
   logic [IDX_W-1:0]      res_free_ff, res_free_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_bit_ff, rsp_bit_in;
   logic [IDX_W-1:0]      rsp_free_ff, rsp_free_in;

   logic [WORD_BITS-1:0]  mem [WORD_COUNT];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [WORD_BITS-1:0]  mem_wdata;
   logic [AW-1:0]         mem_raddr;

   logic                  cfg_wr;
   logic                  req_accept;
   logic                  rsp_free_slot;
   logic [CW-1:0]         quot;
   logic [IDX_W:0]        rem;
   logic [IDX_W-1:0]      rel;
   logic [IDX_W-1:0]      diff;
   logic [IDX_W-1:0]      span;
   logic                  empty;
   logic                  in_range;
   logic [WORD_BITS-1:0]  tail_mask;
   logic [WORD_BITS-1:0]  free_bits;
   logic [WORD_BITS-1:0]  low_one;
   logic [BW-1:0]         hit_pos;
   logic                  hit;
   logic [CW-1:0]         nxt_cursor;

   // csr port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_RANGE_HIGH) ? CSR_DATA_W'(range_high_ff)
                                                : CSR_DATA_W'(range_low_ff);

   // handshakes
   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign req_accept        = req_bus.valid && req_bus.ready;
   assign rsp_free_slot     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.bit_value = rsp_bit_ff;
   assign rsp_bus.free_index = rsp_free_ff;

   // range checks on the latched request
   assign rel      = index_ff - range_low_ff;
   assign diff     = range_high_ff - range_low_ff;
   assign empty    = range_high_ff < range_low_ff;
   assign span     = ({1'b0, diff} > TOTAL_M1) ? TOTAL_M1[IDX_W-1:0] : diff;
   assign in_range = !empty && (index_ff >= range_low_ff) && (index_ff <= range_high_ff)
                     && ({1'b0, rel} <= TOTAL_M1);

   // word/bit split from the registered reciprocal product
   assign quot = prod_ff[SH +: CW];
   assign rem  = {1'b0, op_ff} - (IDX_W+1)'(quot * WORD_BITS);

   // zero-bit search over the word just read
   assign tail_mask = (cursor_ff == word_ff)
                      ? ({WORD_BITS{1'b1}} >> (BW'(WORD_BITS - 1) - bit_ff))
                      : {WORD_BITS{1'b1}};
   assign free_bits = ~rd_data_ff & tail_mask;
   assign low_one   = free_bits & (~free_bits + 1'b1);
   assign hit       = |free_bits;
   assign nxt_cursor = cursor_ff + 1'b1;

   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_one[i]) begin
            hit_pos = hit_pos | BW'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_MUL;
         ST_MUL:  state_in = ST_MOD;
         ST_MOD: begin
            if (!valid_ff) begin
               state_in = ST_RESP;
            end else if (mode_ff == MODE_FIND) begin
               state_in = (cursor_ff > quot) ? ST_RESP : ST_SCAN_RD;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ:    state_in = ST_RMW;
         ST_RMW:     state_in = ST_RESP;
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (hit) begin
               state_in = ST_FOUND;
            end else if (cursor_ff == word_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_FOUND: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free_slot) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cfg_wr) begin
         state_in = ST_CLEAR;
      end
   end

   // datapath and memory controls
   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      clr_addr_in   = clr_addr_ff;
      cursor_in     = cursor_ff;
      mode_in       = mode_ff;
      index_in      = index_ff;
      op_in         = op_ff;
      valid_in      = valid_ff;
      prod_in       = prod_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      res_bit_in    = res_bit_ff;
      res_free_in   = res_free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_bit_in    = rsp_bit_ff;
      rsp_free_in   = rsp_free_ff;
      mem_we        = 1'b0;
      mem_waddr     = word_ff[AW-1:0];
      mem_wdata     = rd_data_ff;
      mem_raddr     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_accept) begin
               mode_in       = req_bus.mode;
               index_in      = req_bus.block_index;
               res_status_in = STATUS_OK;
               res_bit_in    = 1'b0;
               res_free_in   = '0;
            end
         end
         ST_PREP: begin
            op_in    = (mode_ff == MODE_FIND) ? span : rel;
            valid_in = (mode_ff == MODE_FIND) ? !empty : in_range;
         end
         ST_MUL: begin
            prod_in = PW'(op_ff) * PW'(RECIP);
         end
         ST_MOD: begin
            word_in = quot;
            bit_in  = rem[BW-1:0];
            if (!valid_ff) begin
               if (mode_ff == MODE_GET) begin
                  res_status_in = STATUS_BAD_PARAM;
               end else if (mode_ff == MODE_FIND) begin
                  res_status_in = STATUS_FULL;
               end
            end else if ((mode_ff == MODE_FIND) && (cursor_ff > quot)) begin
               res_status_in = STATUS_FULL;
            end
         end
         ST_READ: begin
            mem_raddr = word_ff[AW-1:0];
         end
         ST_RMW: begin
            if (mode_ff == MODE_GET) begin
               res_bit_in = rd_data_ff[bit_ff];
            end else if (mode_ff == MODE_SET) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff | (WORD_BITS'(1) << bit_ff);
            end else begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff & ~(WORD_BITS'(1) << bit_ff);
               if (cursor_ff > word_ff) begin
                  cursor_in = word_ff;
               end
            end
         end
         ST_SCAN_RD: begin
            mem_raddr = cursor_ff[AW-1:0];
         end
         ST_SCAN_CHK: begin
            // fetch the following word while this one is searched
            mem_raddr = nxt_cursor[AW-1:0];
            if (hit) begin
               bit_in = hit_pos;
            end else begin
               cursor_in = nxt_cursor;
               if (cursor_ff == word_ff) begin
                  res_status_in = STATUS_FULL;
               end
            end
         end
         ST_FOUND: begin
            res_free_in = range_low_ff + IDX_W'(cursor_ff * WORD_BITS) + IDX_W'(bit_ff);
         end
         ST_RESP: begin
            if (rsp_free_slot) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bit_in    = res_bit_ff;
               rsp_free_in   = res_free_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase

      // csr write restarts the clearing pass
      if (cfg_wr) begin
         if (paddr[2] == REG_RANGE_LOW) begin
            range_low_in = pwdata[IDX_W-1:0];
         end else begin
            range_high_in = pwdata[IDX_W-1:0];
         end
         clr_addr_in = '0;
         cursor_in   = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
         clr_addr_ff   <= '0;
         cursor_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         clr_addr_ff   <= clr_addr_in;
         cursor_ff     <= cursor_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      index_ff      <= index_in;
      op_ff         <= op_in;
      valid_ff      <= valid_in;
      prod_ff       <= prod_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      res_bit_ff    <= res_bit_in;
      res_free_ff   <= res_free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // bitmap memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // checks
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> state_ff == ST_CLEAR)
      else $error("csr write did not start the clearing pass");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CW'(WORD_COUNT))
      else $error("scan cursor beyond word count");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_RMW))
      else $error("bitmap written outside clear or modify");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && !cfg_wr |=> state_ff == ST_PREP)
      else $error("accepted transaction did not start processing");

endmodule
